// ===== rtl/ftprlp_pkg.sv =====
// ---------------------------------------------------------------------------
// ftprlp_pkg
// Shared constants and types of the control-channel reply line parser.
// ---------------------------------------------------------------------------
`default_nettype none

package ftprlp_pkg;

	// character codes
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;

	// address part phase codes
	localparam logic [2:0] PH_SEEK   = 3'd0;
	localparam logic [2:0] PH_OCTETS = 3'd1;
	localparam logic [2:0] PH_PORT   = 3'd2;
	localparam logic [2:0] PH_DONE   = 3'd3;
	localparam logic [2:0] PH_BAD    = 3'd4;

	// line position where the address part starts, and where it saturates
	localparam logic [2:0] POS_TEXT  = 3'd4;
	localparam logic [2:0] POS_MAX   = 3'd5;

	// number of octet commas before the port part
	localparam logic [2:0] OCTET_COMMAS = 3'd4;

	// largest legal octet value
	localparam logic [19:0] OCTET_MAX = 20'd255;

	// one finished reply line
	typedef struct packed {
		logic [9:0]  reply_code;
		logic        addr_found;
		logic        addr_error;
		logic [31:0] ip_address;
		logic [15:0] server_port;
	} reply_t;

	// decimal digit test
	function automatic logic is_dec(input logic [7:0] b);
		return (b >= CH_ZERO) && (b <= CH_NINE);
	endfunction

endpackage

`default_nettype wire

// ===== rtl/ftprlp_in_reg.sv =====
// ---------------------------------------------------------------------------
// ftprlp_in_reg
// Input register: holds one received byte until the parser consumes it.
// ---------------------------------------------------------------------------
`default_nettype none

module ftprlp_in_reg (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       rx_valid,
	output logic            rx_stall,
	input  wire logic [7:0] rx_byte,
	input  wire logic       advance,
	output logic            valid_s1,
	output logic [7:0]      byte_s1
);
	import ftprlp_pkg::*;

	logic accept;

	// a held byte blocks the channel until the parser takes it
	assign rx_stall = valid_s1 && !advance;
	assign accept   = rx_valid && !rx_stall;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// byte payload
	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= rx_byte;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/ftprlp_core.sv =====
// ---------------------------------------------------------------------------
// ftprlp_core
// Line framing, reply code and address state, updated once per byte.
// ---------------------------------------------------------------------------
`default_nettype none

module ftprlp_core (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic [7:0] byte_s1,
	input  wire logic       step,
	output logic            emit,
	output ftprlp_pkg::reply_t result
);
	import ftprlp_pkg::*;

	logic [2:0]  pos_q, pos_d;
	logic        reply_q, reply_d;
	logic [9:0]  code_q, code_d;
	logic        cr_q, cr_d;
	logic [2:0]  phase_q, phase_d;
	logic [2:0]  comma_q, comma_d;
	logic [15:0] val_q, val_d;
	logic [31:0] oct_q, oct_d;
	logic [7:0]  phb_q, phb_d;

	logic        digit;
	logic [3:0]  dval;
	logic [13:0] code_wide;
	logic [19:0] val_wide;
	logic [2:0]  comma_inc;
	logic        line_end;
	logic        addr_ok;

	// byte decode and multiply-add
	assign digit     = is_dec(byte_s1);
	assign dval      = byte_s1[3:0];
	assign code_wide = {4'd0, code_q} * 14'd10 + {10'd0, dval};
	assign val_wide  = {4'd0, val_q} * 20'd10 + {16'd0, dval};
	assign comma_inc = comma_q + 3'd1;
	assign line_end  = (byte_s1 == CH_LF) && cr_q;

	// result of the line that ends with this byte
	assign emit    = line_end && reply_q;
	assign addr_ok = (phase_q == PH_DONE);
	always_comb begin
		result.reply_code  = code_q;
		result.addr_found  = (phase_q != PH_SEEK);
		result.addr_error  = (phase_q != PH_SEEK) && !addr_ok;
		result.ip_address  = addr_ok ? oct_q : 32'd0;
		result.server_port = addr_ok ? ({phb_q, 8'h00} | val_q) : 16'd0;
	end

	// next state
	always_comb begin
		pos_d   = pos_q;
		reply_d = reply_q;
		code_d  = code_q;
		cr_d    = cr_q;
		phase_d = phase_q;
		comma_d = comma_q;
		val_d   = val_q;
		oct_d   = oct_q;
		phb_d   = phb_q;
		if (line_end) begin
			pos_d   = 3'd0;
			reply_d = 1'b0;
			code_d  = 10'd0;
			cr_d    = 1'b0;
			phase_d = PH_SEEK;
			comma_d = 3'd0;
			val_d   = 16'd0;
			oct_d   = 32'd0;
			phb_d   = 8'd0;
		end else begin
			// reply code prefix "ddd "
			if (pos_q < 3'd3) begin
				if (digit) begin
					if (pos_q == 3'd0) begin
						reply_d = 1'b1;
					end
					code_d = code_wide[9:0];
				end else begin
					reply_d = 1'b0;
				end
			end else if (pos_q == 3'd3) begin
				if (byte_s1 != CH_SPACE) begin
					reply_d = 1'b0;
				end
			end else if (reply_q) begin
				// address part of the reply text
				case (phase_q)
					PH_SEEK: begin
						if (byte_s1 == CH_LPAREN) begin
							phase_d = PH_OCTETS;
						end
					end
					PH_OCTETS: begin
						if (byte_s1 == CH_COMMA) begin
							oct_d   = {oct_q[23:0], val_q[7:0]};
							val_d   = 16'd0;
							comma_d = comma_inc;
							if (comma_inc >= OCTET_COMMAS) begin
								phase_d = PH_PORT;
							end
						end else if (digit) begin
							val_d = val_wide[15:0];
							if (val_wide > OCTET_MAX) begin
								phase_d = PH_BAD;
							end
						end else begin
							phase_d = PH_BAD;
						end
					end
					PH_PORT: begin
						if (byte_s1 == CH_RPAREN) begin
							phase_d = PH_DONE;
						end else if (byte_s1 == CH_COMMA) begin
							phb_d = val_q[7:0];
							val_d = 16'd0;
						end else if (digit) begin
							val_d = val_wide[15:0];
						end else begin
							phase_d = PH_BAD;
						end
					end
					default: begin
					end
				endcase
			end
			cr_d = (byte_s1 == CH_CR) && (pos_q >= POS_TEXT);
			if (pos_q < POS_MAX) begin
				pos_d = pos_q + 3'd1;
			end
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= 3'd0;
			reply_q <= 1'b0;
			code_q  <= 10'd0;
			cr_q    <= 1'b0;
			phase_q <= PH_SEEK;
			comma_q <= 3'd0;
			val_q   <= 16'd0;
			oct_q   <= 32'd0;
			phb_q   <= 8'd0;
		end else if (step) begin
			pos_q   <= pos_d;
			reply_q <= reply_d;
			code_q  <= code_d;
			cr_q    <= cr_d;
			phase_q <= phase_d;
			comma_q <= comma_d;
			val_q   <= val_d;
			oct_q   <= oct_d;
			phb_q   <= phb_d;
		end
	end

	// line position saturates
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_MAX)
		else $error("line position past saturation");

	// port part only after all octet commas
	a_port_commas: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_PORT || phase_q == PH_DONE) |-> (comma_q == OCTET_COMMAS))
		else $error("port part entered with wrong comma count");

	// address parsing only inside a reply text
	a_addr_in_reply: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_SEEK) |-> (reply_q && pos_q == POS_MAX))
		else $error("address phase outside reply text");

endmodule

`default_nettype wire

// ===== rtl/ftprlp_out_reg.sv =====
// ---------------------------------------------------------------------------
// ftprlp_out_reg
// Result register: holds a finished reply until the consumer takes it.
// ---------------------------------------------------------------------------
`default_nettype none

module ftprlp_out_reg (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               load,
	input  wire ftprlp_pkg::reply_t result,
	output logic                    out_free,
	output logic                    reply_valid,
	input  wire logic               reply_stall,
	output ftprlp_pkg::reply_t      reply_q
);
	import ftprlp_pkg::*;

	// room for a new result once the held one is taken
	assign out_free = !reply_valid || !reply_stall;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reply_valid <= 1'b0;
		end else if (load) begin
			reply_valid <= 1'b1;
		end else if (!reply_stall) begin
			reply_valid <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (load) begin
			reply_q <= result;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/ftp_reply_line_parser.sv =====
// ---------------------------------------------------------------------------
// ftp_reply_line_parser
// Frames control-channel bytes into lines and reports reply code and address.
// ---------------------------------------------------------------------------
//
//   channel  direction  handshake               payload
//   rx       in         rx_valid / rx_stall     rx_byte
//   reply    out        reply_valid / reply_stall
//                       reply_code, addr_found, addr_error, ip_address, server_port
//
// one byte per cycle unless the parser is held; a taken byte sits in the input
// register until consumed; a reply is registered when its closing LF is consumed.
// the parser state updates in a single multiply-add step per byte.
// reset clears all line state; no result is pending afterwards.
// a stalled reply holds the parser only when the next byte ends a reply line;
// other bytes keep flowing while a result waits.
`default_nettype none

module ftp_reply_line_parser (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        rx_valid,
	output logic             rx_stall,
	input  wire logic [7:0]  rx_byte,
	output logic             reply_valid,
	input  wire logic        reply_stall,
	output logic [9:0]       reply_code,
	output logic             addr_found,
	output logic             addr_error,
	output logic [31:0]      ip_address,
	output logic [15:0]      server_port
);
	import ftprlp_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       advance;
	logic       emit;
	logic       out_free;
	reply_t     result;
	reply_t     reply_q;

	// input register
	ftprlp_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_valid (rx_valid),
		.rx_stall (rx_stall),
		.rx_byte  (rx_byte),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	// a byte moves on unless it ends a reply and the result register is full
	assign advance = valid_s1 && (!emit || out_free);

	// parser state
	ftprlp_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.byte_s1 (byte_s1),
		.step    (advance),
		.emit    (emit),
		.result  (result)
	);

	// result register
	ftprlp_out_reg u_out_reg (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (advance && emit),
		.result      (result),
		.out_free    (out_free),
		.reply_valid (reply_valid),
		.reply_stall (reply_stall),
		.reply_q     (reply_q)
	);

	// output fields
	assign reply_code  = reply_q.reply_code;
	assign addr_found  = reply_q.addr_found;
	assign addr_error  = reply_q.addr_error;
	assign ip_address  = reply_q.ip_address;
	assign server_port = reply_q.server_port;

endmodule

`default_nettype wire

// ===== verif/tb_ftp_reply_line_parser.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_ftp_reply_line_parser
// Feeds control-channel bytes through the reply line parser under random
// idling and stalling on both channels. A line parser kept in the bench
// predicts each finished reply (code, address flags, address and port),
// unless a typed reply stands in on a directed line; each reply the block
// hands out is compared field by field with the oldest prediction. The bytes
// 00, FF and the table of hand-written lines come first, then random well-formed and broken
// lines, with one long receiver hold-off and pauses of the sender until all replies are in.
// ---------------------------------------------------------------------------

module tb_ftp_reply_line_parser;

	import ftprlp_pkg::*;

	localparam int unsigned N_BYTES = 1700;
	localparam int unsigned LIMIT   = 400000;
	localparam int unsigned HOLD    = 300;
	localparam int          N_DIR   = 19;

	logic        clk;
	logic        arst_n      = 1'b0;
	logic        rx_valid    = 1'b0;
	logic        rx_stall;
	logic [7:0]  rx_byte     = 8'h00;
	logic        reply_valid;
	logic        reply_stall = 1'b0;
	logic [9:0]  reply_code;
	logic        addr_found;
	logic        addr_error;
	logic [31:0] ip_address;
	logic [15:0] server_port;

	// bench-side tag riding along with each request: a hand-typed reply
	logic        rx_tag  = 1'b0;
	reply_t      rx_want = '0;

	reply_t      pending_replies[$];
	logic [7:0]  pend[$];

	int unsigned errors    = 0;
	int unsigned n_bytes   = 0;
	int unsigned n_checked = 0;
	int unsigned n_addr    = 0;
	int unsigned n_bad     = 0;
	int unsigned cycles    = 0;
	bit          quick_tx  = 1'b0;
	bit          hold_replies = 1'b0;

	// line parser state
	logic [2:0]  ln_pos;
	logic        is_reply;
	logic [9:0]  code_acc;
	logic        cr_seen;
	logic [2:0]  addr_ph;
	logic [2:0]  n_commas;
	logic [15:0] val_acc;
	logic [31:0] octets;
	logic [7:0]  port_hi;

	// directed lines; a typed reply only where it is obvious
	string dir_txt [N_DIR] = '{
		"zz\015\012",
		"200 OK\015\012",
		"227 Entering Passive Mode (192,168,1,2,19,137).\015\012",
		"999 (255,255,255,255,255,255)\015\012",
		"000 (0,0,0,0,0,0)\015\012",
		"123-multi line\015\012",
		"1234 x\015\012",
		"abc\015\012\015\012",
		"250 a\015b\012c\015\012",
		"227 (256,1,1,1,1,1)\015\012",
		"227 (1,,3,4,5,6)\015\012",
		"227 (1,2,x,4,5,6)\015\012",
		"227 (1,2,3,4,5,6\015\012",
		"227 (10,0,0,1,99999)\015\012",
		"229 (1,2,3,4,5,6,7,300)\015\012",
		"227 (1,2,3,4,5,6) ok (9\015\012",
		"331 \015\012",
		"\012500 x\015\012",
		"421 (1,2,3,4,5\377)\015\012"
	};
	bit dir_typed [N_DIR] = '{0, 1, 0, 1, 1, 0, 0, 0, 1, 1, 0, 1, 1, 0, 0, 0, 1, 0, 1};
	reply_t dir_want [N_DIR] = '{
		'0,
		{10'd200, 1'b0, 1'b0, 32'h0000_0000, 16'h0000},
		'0,
		{10'd999, 1'b1, 1'b0, 32'hFFFF_FFFF, 16'hFFFF},
		{10'd0,   1'b1, 1'b0, 32'h0000_0000, 16'h0000},
		'0,
		'0,
		'0,
		{10'd250, 1'b0, 1'b0, 32'h0000_0000, 16'h0000},
		{10'd227, 1'b1, 1'b1, 32'h0000_0000, 16'h0000},
		'0,
		{10'd227, 1'b1, 1'b1, 32'h0000_0000, 16'h0000},
		{10'd227, 1'b1, 1'b1, 32'h0000_0000, 16'h0000},
		'0,
		'0,
		'0,
		{10'd331, 1'b0, 1'b0, 32'h0000_0000, 16'h0000},
		'0,
		{10'd421, 1'b1, 1'b1, 32'h0000_0000, 16'h0000}
	};

	ftp_reply_line_parser dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.rx_valid    (rx_valid),
		.rx_stall    (rx_stall),
		.rx_byte     (rx_byte),
		.reply_valid (reply_valid),
		.reply_stall (reply_stall),
		.reply_code  (reply_code),
		.addr_found  (addr_found),
		.addr_error  (addr_error),
		.ip_address  (ip_address),
		.server_port (server_port)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles, %0d replies outstanding", cycles,
				pending_replies.size());
			$display("tb_ftp_reply_line_parser: errors");
			$finish;
		end
	end

	function automatic bit digit_byte(input logic [7:0] b);
		return b >= CH_ZERO && b <= CH_NINE;
	endfunction

	function automatic void start_new_line();
		ln_pos   = '0;
		is_reply = 1'b0;
		code_acc = '0;
		cr_seen  = 1'b0;
		addr_ph  = PH_SEEK;
		n_commas = '0;
		val_acc  = '0;
		octets   = '0;
		port_hi  = '0;
	endfunction

	// address text after the reply code
	function automatic void parse_addr_byte(input logic [7:0] b);
		logic [7:0]  dig;
		logic [31:0] wide;
		dig = b - CH_ZERO;
		case (addr_ph)
			PH_SEEK: begin
				if (b == CH_LPAREN)
					addr_ph = PH_OCTETS;
			end
			PH_OCTETS: begin
				if (b == CH_COMMA) begin
					octets   = {octets[23:0], val_acc[7:0]};
					val_acc  = '0;
					n_commas = n_commas + 3'd1;
					if (n_commas >= OCTET_COMMAS)
						addr_ph = PH_PORT;
				end else if (digit_byte(b)) begin
					wide    = val_acc * 32'd10 + dig;
					val_acc = wide[15:0];
					if (wide > 32'd255)
						addr_ph = PH_BAD;
				end else begin
					addr_ph = PH_BAD;
				end
			end
			PH_PORT: begin
				if (b == CH_RPAREN) begin
					addr_ph = PH_DONE;
				end else if (b == CH_COMMA) begin
					port_hi = val_acc[7:0];
					val_acc = '0;
				end else if (digit_byte(b)) begin
					wide    = val_acc * 32'd10 + dig;
					val_acc = wide[15:0];
				end else begin
					addr_ph = PH_BAD;
				end
			end
			default: ;
		endcase
	endfunction

	// one byte through the line parser; 1 when a reply line finishes
	function automatic bit parse_byte(input logic [7:0] b, output reply_t r);
		logic [2:0]  p;
		logic [31:0] wide;
		bit          done;
		p = ln_pos;
		r = '0;
		if (b == CH_LF && cr_seen) begin
			done          = is_reply;
			r.reply_code  = code_acc;
			r.addr_found  = addr_ph != PH_SEEK;
			r.addr_error  = addr_ph != PH_SEEK && addr_ph != PH_DONE;
			r.ip_address  = (addr_ph == PH_DONE) ? octets : 32'h0;
			r.server_port = (addr_ph == PH_DONE) ? ({port_hi, 8'h00} | val_acc) : 16'h0;
			start_new_line();
			return done;
		end
		if (p < 3'd3) begin
			if (digit_byte(b)) begin
				if (p == 3'd0)
					is_reply = 1'b1;
				wide     = code_acc * 32'd10 + (b - CH_ZERO);
				code_acc = wide[9:0];
			end else begin
				is_reply = 1'b0;
			end
		end else if (p == 3'd3) begin
			if (b != CH_SPACE)
				is_reply = 1'b0;
		end else if (is_reply) begin
			parse_addr_byte(b);
		end
		cr_seen = (b == CH_CR && p >= POS_TEXT);
		if (ln_pos < POS_MAX)
			ln_pos = ln_pos + 3'd1;
		return 1'b0;
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
		input logic [31:0] seen);
		if (seen !== want) begin
			$error("%s: expected %0d, actual %0d", name, want, seen);
			errors++;
		end
	endfunction

	// predict on accepted requests, check accepted replies
	always @(posedge clk) begin
		reply_t want;
		reply_t predicted;
		bit     made;
		if (reply_valid && !reply_stall) begin
			if (pending_replies.size() == 0) begin
				$error("reply with nothing expected: code %0d", reply_code);
				errors++;
			end else begin
				want = pending_replies.pop_front();
				check_field("reply_code", want.reply_code, reply_code);
				check_field("addr_found", want.addr_found, addr_found);
				check_field("addr_error", want.addr_error, addr_error);
				check_field("ip_address", want.ip_address, ip_address);
				check_field("server_port", want.server_port, server_port);
				n_checked++;
				if (want.addr_found)
					n_addr++;
				if (want.addr_error)
					n_bad++;
			end
		end
		if (rx_valid && !rx_stall) begin
			made = parse_byte(rx_byte, predicted);
			if (rx_tag)
				pending_replies.push_back(rx_want);
			else if (made)
				pending_replies.push_back(predicted);
		end
	end

	// receiver: random stall before each reply, one long hold-off on request
	initial begin
		int unsigned n;
		int unsigned quick;
		quick = 0;
		forever begin
			if (hold_replies) begin
				n = HOLD;
				hold_replies = 1'b0;
			end else if (quick != 0) begin
				n = 0;
				quick--;
			end else begin
				n = $urandom_range(0, 17);
				if ($urandom_range(0, 9) == 0)
					quick = $urandom_range(5, 20);
			end
			if (n != 0) begin
				reply_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			reply_stall <= 1'b0;
			do @(posedge clk); while (!reply_valid && !hold_replies);
		end
	end

	// one request, after a random gap unless in a quick stretch
	task automatic send_byte(input logic [7:0] b, input logic tag, input reply_t want);
		int unsigned gap;
		gap = quick_tx ? 0 : $urandom_range(0, 17);
		if (gap != 0) begin
			rx_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rx_valid <= 1'b1;
		rx_byte  <= b;
		rx_tag   <= tag;
		rx_want  <= want;
		do @(posedge clk); while (rx_stall);
		n_bytes++;
	endtask

	// send the assembled line; a typed reply rides on its last byte
	task automatic send_pend(input bit typed, input reply_t want);
		logic [7:0] b;
		while (pend.size() != 0) begin
			b = pend.pop_front();
			send_byte(b, typed && pend.size() == 0, want);
		end
	endtask

	task automatic wait_drained(input int unsigned limit);
		int unsigned i;
		i = 0;
		while (pending_replies.size() != 0 && i < limit) begin
			@(posedge clk);
			i++;
		end
	endtask

	function automatic void put_text(input string s);
		for (int i = 0; i < s.len(); i++)
			pend.push_back(s[i]);
	endfunction

	function automatic void put_num(input int unsigned v);
		put_text($sformatf("%0d", v));
	endfunction

	// free text, with the odd lone cr or lf
	function automatic void put_rand_text(input int unsigned count);
		int unsigned sel;
		repeat (count) begin
			sel = $urandom_range(0, 19);
			if (sel == 0)
				pend.push_back(CH_CR);
			else if (sel == 1)
				pend.push_back(CH_LF);
			else
				pend.push_back(8'($urandom_range(32, 126)));
		end
	endfunction

	// random line: mostly address replies, then plain replies, continuations, noise
	function automatic void make_random_line();
		int unsigned kind;
		int unsigned sel;
		int unsigned np;
		int unsigned at;
		kind = $urandom_range(0, 99);
		if (kind < 85) begin
			repeat (3) pend.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
		end
		if (kind < 60) begin
			pend.push_back(CH_SPACE);
			put_rand_text($urandom_range(0, 8));
			pend.push_back(CH_LPAREN);
			for (int k = 0; k < 4; k++) begin
				if (k != 0)
					pend.push_back(CH_COMMA);
				sel = $urandom_range(0, 19);
				if (sel == 1)
					put_num($urandom_range(256, 999));
				else if (sel != 0)
					put_num($urandom_range(0, 255));
			end
			np = ($urandom_range(0, 9) < 7) ? 2 : $urandom_range(0, 3);
			repeat (np) begin
				pend.push_back(CH_COMMA);
				if ($urandom_range(0, 9) == 0)
					put_num($urandom_range(0, 99999));
				else
					put_num($urandom_range(0, 255));
			end
			if ($urandom_range(0, 9) != 0)
				pend.push_back(CH_RPAREN);
			put_rand_text($urandom_range(0, 4));
			if ($urandom_range(0, 11) == 0) begin
				at = $urandom_range(0, pend.size() - 1);
				pend[at] = 8'($urandom_range(0, 255));
			end
		end else if (kind < 75) begin
			pend.push_back(CH_SPACE);
			put_rand_text($urandom_range(0, 10));
		end else if (kind < 85) begin
			pend.push_back(($urandom_range(0, 1) == 0) ? 8'h2D : 8'($urandom_range(0, 255)));
			put_rand_text($urandom_range(0, 8));
		end else begin
			repeat ($urandom_range(1, 10)) pend.push_back(8'($urandom_range(0, 255)));
		end
		pend.push_back(CH_CR);
		pend.push_back(CH_LF);
	endfunction

	// main sequence
	initial begin
		int unsigned lines;
		lines = 0;
		start_new_line();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// byte extremes, then the directed table
		send_byte(8'h00, 1'b0, '0);
		send_byte(8'hFF, 1'b0, '0);
		for (int r = 0; r < N_DIR; r++) begin
			put_text(dir_txt[r]);
			send_pend(dir_typed[r], dir_want[r]);
		end
		rx_valid <= 1'b0;
		wait_drained(LIMIT);

		// random lines
		while (n_bytes < N_BYTES) begin
			quick_tx = ($urandom_range(0, 6) == 0);
			if (lines == 25) begin
				// receiver holds off while short replies pile up behind it
				hold_replies = 1'b1;
				quick_tx     = 1'b1;
				for (int k = 0; k < 8; k++) begin
					put_text($sformatf("2%02d x\015\012", k));
					send_pend(1'b0, '0);
				end
			end
			if (lines == 50) begin
				rx_valid <= 1'b0;
				wait_drained(LIMIT);
			end
			make_random_line();
			send_pend(1'b0, '0);
			lines++;
		end
		rx_valid <= 1'b0;

		wait_drained(5000);
		if (pending_replies.size() != 0) begin
			$error("%0d replies never arrived", pending_replies.size());
			errors++;
		end
		repeat (10) @(posedge clk);

		$display("%0d bytes in %0d random lines plus directed lines; %0d replies checked",
			n_bytes, lines, n_checked);
		$display("%0d replies carried an address part, %0d of them flagged bad",
			n_addr, n_bad);
		if (errors == 0)
			$display("tb_ftp_reply_line_parser: clean");
		else
			$display("tb_ftp_reply_line_parser: errors");
		$finish;
	end

endmodule
